// ----- sv/i2cm_pkg.sv -----
// Types, codes and reset constants shared by the I2C bit-level master.
package i2cm_pkg;

    // Command codes carried in the mode field of a request
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam int unsigned BYTE_BITS = 8;
    localparam logic [7:0] ACK_LIMIT_RESET = 8'd255;

    // Write sequence phases
    localparam logic [2:0] WR_SCL_LOW  = 3'd0;
    localparam logic [2:0] WR_SDA_BIT  = 3'd1;
    localparam logic [2:0] WR_SCL_HIGH = 3'd2;
    localparam logic [2:0] WR_SCL_DROP = 3'd3;
    localparam logic [2:0] WR_RELEASE  = 3'd4;
    localparam logic [2:0] WR_ACK_SCL  = 3'd5;
    localparam logic [2:0] WR_POLL     = 3'd6;
    localparam logic [2:0] WR_FINISH   = 3'd7;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       last_read;
        logic       sda_sample;
    } t_in_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_enable;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       rejected;
    } t_out_res;

    typedef struct packed {
        t_op        op;
        logic       active;
        logic [2:0] phase;
        logic [3:0] bit_idx;
        logic [7:0] shift;
        logic [7:0] ack_cnt;
        logic       nack_req;
        logic       ack_seen;
        logic       scl;
        logic       oe;
        logic       sda;
        logic [7:0] last_rx;
    } t_state;

    localparam t_state STATE_RESET = '{
        op:       OP_START,
        active:   1'b0,
        phase:    3'd0,
        bit_idx:  4'd0,
        shift:    8'd0,
        ack_cnt:  8'd0,
        nack_req: 1'b0,
        ack_seen: 1'b0,
        scl:      1'b1,
        oe:       1'b1,
        sda:      1'b1,
        last_rx:  8'd0
    };

endpackage

// ----- sv/i2c_bit_level_master_top.sv -----
// Top level of the I2C bit-level master: state, result register and handshakes.
//
// I2C master that sequences SCL and SDA one bus phase per tick request. While
// idle it takes a command (start, stop, write byte, read byte with ACK or
// NACK); each later tick request advances the sequence by one phase and each
// request of any kind yields exactly one result with the pin levels, busy,
// done, the last received byte, a missing-ACK flag and a rejected-command
// flag. A request is taken in the cycle it arrives: the whole phase step is a
// single pass of logic from the request and the state registers into the
// result register, so one request per clock is sustained. The input side
// stalls only while a result is held in the output register and the
// consumer is stalling it. The user must write ack_wait_limit via i_cfg_we and
// i_cfg_wdata only while idle; the block does not enforce it. It resets to 255.
module i2c_bit_level_master_top
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_req    i_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_res   o_out
);

    t_state     r_state;
    t_state     n_state;
    t_out_res   r_out;
    t_out_res   n_out;
    logic       r_out_valid;
    logic [7:0] r_ack_limit;
    logic       accept;

    // the result register frees up in the same cycle it is taken
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    i2cm_core u_core (
        .i_state     (r_state),
        .i_req       (i_in),
        .i_ack_limit (r_ack_limit),
        .o_state     (n_state),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
            r_ack_limit <= ACK_LIMIT_RESET;
        end else begin
            if (i_cfg_we) r_ack_limit <= i_cfg_wdata;
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- sv/i2cm_core.sv -----
// Next-state and result logic for one request of the I2C bit-level master.
module i2cm_core
    import i2cm_pkg::*;
(
    input  t_state     i_state,
    input  t_in_req    i_req,
    input  logic [7:0] i_ack_limit,
    output t_state     o_state,
    output t_out_res   o_res
);

    logic       done;
    logic       no_ack;
    logic       rej;
    logic [1:0] p;
    logic [3:0] bit_next;
    logic [7:0] cnt_next;

    assign p        = i_state.phase[1:0];
    assign bit_next = i_state.bit_idx + 4'd1;
    assign cnt_next = i_state.ack_cnt + 8'd1;

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        no_ack  = 1'b0;
        rej     = 1'b0;

        if (i_req.mode inside {[MODE_START:MODE_READ]}) begin
            if (i_state.active) begin
                rej = 1'b1;
            end else begin
                o_state.op       = t_op'(i_req.mode[1:0]);
                o_state.active   = 1'b1;
                o_state.phase    = 3'd0;
                o_state.bit_idx  = 4'd0;
                o_state.ack_cnt  = 8'd0;
                o_state.ack_seen = 1'b0;
                o_state.nack_req = i_req.last_read;
                o_state.shift    = (i_req.mode == MODE_WRITE) ? i_req.data_byte : 8'd0;
            end
        end else if (i_req.mode == MODE_TICK && i_state.active) begin
            case (i_state.op)
                OP_START, OP_STOP: begin
                    o_state.oe = 1'b1;
                    case (p)
                        2'd0: begin
                            o_state.sda = (i_state.op == OP_START);
                        end
                        2'd1: begin
                            o_state.scl = (i_state.op == OP_START);
                        end
                        2'd2: begin
                            if (i_state.op == OP_START) o_state.sda = 1'b0;
                            else                        o_state.scl = 1'b1;
                        end
                        default: begin
                            if (i_state.op == OP_START) o_state.scl = 1'b0;
                            else                        o_state.sda = 1'b1;
                        end
                    endcase
                    o_state.phase = {1'b0, p} + 3'd1;
                    done = (p == 2'd3);
                end
                OP_WRITE: begin
                    case (i_state.phase)
                        WR_SCL_LOW: begin
                            o_state.scl   = 1'b0;
                            o_state.phase = WR_SDA_BIT;
                        end
                        WR_SDA_BIT: begin
                            o_state.oe    = 1'b1;
                            o_state.sda   = i_state.shift[7];
                            o_state.shift = {i_state.shift[6:0], 1'b0};
                            o_state.phase = WR_SCL_HIGH;
                        end
                        WR_SCL_HIGH: begin
                            o_state.scl   = 1'b1;
                            o_state.phase = WR_SCL_DROP;
                        end
                        WR_SCL_DROP: begin
                            o_state.scl     = 1'b0;
                            o_state.bit_idx = bit_next;
                            o_state.phase   = (bit_next >= 4'(BYTE_BITS)) ? WR_RELEASE
                                                                         : WR_SDA_BIT;
                        end
                        WR_RELEASE: begin
                            o_state.oe    = 1'b0;
                            o_state.sda   = 1'b1;
                            o_state.phase = WR_ACK_SCL;
                        end
                        WR_ACK_SCL: begin
                            o_state.scl     = 1'b1;
                            o_state.ack_cnt = 8'd0;
                            o_state.phase   = WR_POLL;
                        end
                        WR_POLL: begin
                            if (!i_req.sda_sample) begin
                                o_state.ack_seen = 1'b1;
                                o_state.scl      = 1'b0;
                                o_state.phase    = WR_FINISH;
                            end else begin
                                o_state.ack_cnt = cnt_next;
                                if (cnt_next >= i_ack_limit) begin
                                    o_state.scl   = 1'b0;
                                    o_state.phase = WR_FINISH;
                                end
                            end
                        end
                        default: begin
                            o_state.oe  = 1'b1;
                            o_state.sda = 1'b1;
                            no_ack      = !i_state.ack_seen;
                            done        = 1'b1;
                        end
                    endcase
                end
                default: begin
                    // read: eight sampled bits, then the ACK/NACK slot
                    if (i_state.bit_idx < 4'(BYTE_BITS)) begin
                        case (p)
                            2'd0: begin
                                o_state.oe  = 1'b0;
                                o_state.sda = 1'b1;
                                o_state.scl = 1'b0;
                            end
                            2'd1: o_state.scl = 1'b1;
                            2'd2: ;
                            default: begin
                                o_state.shift   = {i_state.shift[6:0], i_req.sda_sample};
                                o_state.scl     = 1'b0;
                                o_state.bit_idx = bit_next;
                            end
                        endcase
                        o_state.phase = {1'b0, p + 2'd1};
                    end else begin
                        case (p)
                            2'd0: begin
                                o_state.oe  = 1'b1;
                                o_state.scl = 1'b0;
                            end
                            2'd1: o_state.sda = i_state.nack_req;
                            2'd2: o_state.scl = 1'b1;
                            default: begin
                                o_state.scl     = 1'b0;
                                o_state.last_rx = i_state.shift;
                                done            = 1'b1;
                            end
                        endcase
                        if (p != 2'd3) o_state.phase = {1'b0, p + 2'd1};
                    end
                end
            endcase
            if (done) o_state.active = 1'b0;
        end
    end

    assign o_res = '{
        scl_level:        o_state.scl,
        sda_drive_enable: o_state.oe,
        sda_level:        o_state.sda,
        busy_res:         o_state.active,
        done_res:         done,
        rx_byte:          o_state.last_rx,
        ack_missing:      no_ack,
        rejected:         rej
    };

endmodule

// ----- sv/i2cm_checker.sv -----
// Port-level checks for the I2C bit-level master, bound to the top level.
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out
);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> !o_out.busy_res)
        else $error("done reported while still busy");

    a_nack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.ack_missing |-> o_out.done_res && !o_out.rejected)
        else $error("missing ACK flagged outside a finishing tick");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.rejected |-> o_out.busy_res && !o_out.done_res)
        else $error("rejected request while not busy");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.sda_drive_enable |-> o_out.sda_level)
        else $error("SDA level low while released");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
